FILE: hw/rtl/mos_pkg.sv
// Shared types and constants for the generic on/off server.
package mos_pkg;

    localparam logic [1:0] OP_GET       = 2'd0;
    localparam logic [1:0] OP_SET_ACK   = 2'd1;
    localparam logic [1:0] OP_SET_UNACK = 2'd2;
    localparam logic [1:0] OP_TICK      = 2'd3;

    localparam int TIME_W   = 26;
    localparam int DELAY_W  = 11;
    localparam int RES_W    = 20;
    localparam int RECIP_W  = 28;
    localparam int YS_W     = 20;
    localparam int PROD_W   = YS_W + RECIP_W;
    localparam int RECIP_SH = 32;

    localparam logic [5:0] STEPS_PROHIBITED = 6'h3f;
    localparam logic [7:0] CODE_OVERFLOW    = 8'h3f;
    localparam logic [7:0] DELAY_UNIT_MS    = 8'd5;

    // Step resolutions: 100 ms, 1 s, 10 s, 10 min
    localparam logic [RES_W-1:0] RES_MS [4] = '{
        20'd100, 20'd1000, 20'd10000, 20'd600000
    };

    // 63 steps at each resolution
    localparam logic [TIME_W-1:0] RES_LIMIT [4] = '{
        26'd6300, 26'd63000, 26'd630000, 26'd37800000
    };

    // Resolution = 2^RES_SHIFT * odd part; RES_RECIP = ceil(2^32 / odd part)
    localparam logic [2:0] RES_SHIFT [4] = '{3'd2, 3'd3, 3'd4, 3'd6};
    localparam logic [RECIP_W-1:0] RES_RECIP [4] = '{
        28'd171798692, 28'd34359739, 28'd6871948, 28'd458130
    };

    typedef struct packed {
        logic [1:0]  opcode;
        logic        new_value;
        logic [7:0]  transaction_id;
        logic [15:0] source_address;
        logic        has_timing;
        logic [7:0]  transition_code;
        logic [7:0]  delay_code;
    } t_in_item;

    typedef struct packed {
        logic       status_valid;
        logic       present_value;
        logic       has_target;
        logic       target_value;
        logic [7:0] remaining_code;
        logic       led_on;
    } t_out_item;

endpackage

FILE: hw/rtl/mesh_onoff_server_unit.sv
// Generic on/off server: set filtering, delay and transition timer, status encoder.
// A transaction accepted into the input register has its result registered in the
// result register. Throughput: one transaction per cycle unless i_stall holds the
// output; the two registers form two stages, and server state updates in the second.
// Reset: synchronous, active low; clears both stage valids and all server state.
module mesh_onoff_server_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mos_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output mos_pkg::t_out_item  o_result
);

    typedef struct packed {
        logic [1:0]                    op;
        logic                          val;
        logic [7:0]                    tid;
        logic [15:0]                   src;
        logic                          ignore;
        logic [mos_pkg::TIME_W-1:0]    trans_ms;
        logic [mos_pkg::DELAY_W-1:0]   delay_ms;
    } t_stage;

    logic                           r_s1_valid;
    t_stage                         r_s1;
    t_stage                         n_s1;
    logic                           r_out_valid;
    mos_pkg::t_out_item             r_out;
    mos_pkg::t_out_item             n_out;

    logic                           r_cur;
    logic [7:0]                     r_last_tid;
    logic [15:0]                    r_last_src;
    logic [mos_pkg::TIME_W-1:0]     r_pend;
    logic [mos_pkg::TIME_W-1:0]     r_timer;
    logic                           r_armed;
    logic                           r_led;

    logic                           n_cur;
    logic [7:0]                     n_last_tid;
    logic [15:0]                    n_last_src;
    logic [mos_pkg::TIME_W-1:0]     n_pend;
    logic [mos_pkg::TIME_W-1:0]     n_timer;
    logic                           n_armed;
    logic                           n_led;

    logic                           in_acc;
    logic                           s1_adv;
    logic [5:0]                     in_steps;
    logic [1:0]                     in_res;

    logic                           is_set;
    logic                           set_take;
    logic                           fire;
    logic                           status_en;
    logic [mos_pkg::TIME_W-1:0]     tick_timer;
    logic [mos_pkg::TIME_W-1:0]     rem;
    logic [1:0]                     enc_sel;
    logic                           enc_over;
    logic [mos_pkg::TIME_W-1:0]     enc_y;
    logic [mos_pkg::YS_W-1:0]       enc_ys;
    logic [mos_pkg::PROD_W-1:0]     enc_prod;
    logic [7:0]                     enc_code;

    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Input stage: decode transition time and delay
    assign in_steps = i_item.transition_code[5:0];
    assign in_res   = i_item.transition_code[7:6];

    always_comb begin
        n_s1.op     = i_item.opcode;
        n_s1.val    = i_item.new_value;
        n_s1.tid    = i_item.transaction_id;
        n_s1.src    = i_item.source_address;
        n_s1.ignore = i_item.has_timing && (in_steps == mos_pkg::STEPS_PROHIBITED);
        if (i_item.has_timing) begin
            n_s1.trans_ms = mos_pkg::TIME_W'(in_steps)
                          * mos_pkg::TIME_W'(mos_pkg::RES_MS[in_res]);
            n_s1.delay_ms = mos_pkg::DELAY_W'(i_item.delay_code)
                          * mos_pkg::DELAY_W'(mos_pkg::DELAY_UNIT_MS);
        end else begin
            n_s1.trans_ms = '0;
            n_s1.delay_ms = '0;
        end
    end

    // Second stage: state update, status, expiry
    assign is_set     = (r_s1.op == mos_pkg::OP_SET_ACK) || (r_s1.op == mos_pkg::OP_SET_UNACK);
    assign set_take   = is_set && !r_s1.ignore
                      && !(r_s1.tid == r_last_tid && r_s1.src == r_last_src)
                      && (r_s1.val != r_cur);
    assign tick_timer = r_timer - mos_pkg::TIME_W'(1);
    assign status_en  = (r_s1.op == mos_pkg::OP_GET)
                      || (r_s1.op == mos_pkg::OP_SET_ACK && !r_s1.ignore);

    always_comb begin
        n_cur      = r_cur;
        n_last_tid = r_last_tid;
        n_last_src = r_last_src;
        n_pend     = r_pend;
        n_timer    = r_timer;
        n_armed    = r_armed;
        n_led      = r_led;
        fire       = 1'b0;
        if (set_take) begin
            n_cur      = r_s1.val;
            n_last_tid = r_s1.tid;
            n_last_src = r_s1.src;
            n_pend     = r_s1.trans_ms;
            n_timer    = mos_pkg::TIME_W'(r_s1.delay_ms);
            n_armed    = 1'b1;
            fire       = (r_s1.delay_ms == '0);
        end else if (r_s1.op == mos_pkg::OP_TICK && r_armed) begin
            n_timer = tick_timer;
            fire    = (tick_timer == '0);
        end

        // status sees the state before expiry
        rem = (n_armed ? n_timer : '0) + n_pend;

        if (fire) begin
            if (n_pend != '0) begin
                n_led   = 1'b1;
                n_timer = n_pend;
                n_pend  = '0;
                n_armed = 1'b1;
            end else begin
                n_led   = n_cur;
                n_armed = 1'b0;
                n_timer = '0;
            end
        end
    end

    // Remaining time encoder: ceil(rem / res) via shift and reciprocal multiply
    always_comb begin
        enc_over = 1'b0;
        if (rem < mos_pkg::RES_LIMIT[0]) begin
            enc_sel = 2'd0;
        end else if (rem < mos_pkg::RES_LIMIT[1]) begin
            enc_sel = 2'd1;
        end else if (rem < mos_pkg::RES_LIMIT[2]) begin
            enc_sel = 2'd2;
        end else begin
            enc_sel  = 2'd3;
            enc_over = (rem >= mos_pkg::RES_LIMIT[3]);
        end
        enc_y    = rem + mos_pkg::TIME_W'(mos_pkg::RES_MS[enc_sel]) - mos_pkg::TIME_W'(1);
        enc_ys   = mos_pkg::YS_W'(enc_y >> mos_pkg::RES_SHIFT[enc_sel]);
        enc_prod = mos_pkg::PROD_W'(enc_ys) * mos_pkg::PROD_W'(mos_pkg::RES_RECIP[enc_sel]);
        if (enc_over) begin
            enc_code = mos_pkg::CODE_OVERFLOW;
        end else begin
            enc_code = {enc_sel, enc_prod[mos_pkg::RECIP_SH +: 6]};
        end
    end

    always_comb begin
        n_out = '0;
        n_out.led_on = n_led;
        if (status_en) begin
            n_out.status_valid = 1'b1;
            if (rem != '0) begin
                n_out.present_value  = ~n_cur;
                n_out.has_target     = 1'b1;
                n_out.target_value   = n_cur;
                n_out.remaining_code = enc_code;
            end else begin
                n_out.present_value = n_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur       <= 1'b0;
            r_last_tid  <= '0;
            r_last_src  <= '0;
            r_pend      <= '0;
            r_timer     <= '0;
            r_armed     <= 1'b0;
            r_led       <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_cur       <= n_cur;
                r_last_tid  <= n_last_tid;
                r_last_src  <= n_last_src;
                r_pend      <= n_pend;
                r_timer     <= n_timer;
                r_armed     <= n_armed;
                r_led       <= n_led;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: tb/mesh_onoff_server_unit_test.sv
// Self-checking testbench for the generic on/off server: directed table, random traffic.
`timescale 1ns / 100ps
module mesh_onoff_server_unit_test;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    localparam int HOLD_CYCLES  = 200;
    localparam int N_ITEMS      = 500;
    localparam int DRAIN_CYCLES = 10;
    localparam int RUN_LIMIT_NS = 20_000_000;
    localparam int STEP_MS [4]  = '{100, 1000, 10000, 600000};

    typedef struct {
        mos_pkg::t_in_item  item;
        bit                 typed;
        mos_pkg::t_out_item result;
    } t_table_row;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    mos_pkg::t_in_item  i_item  = '0;
    logic               o_stall;
    logic               o_valid;
    mos_pkg::t_out_item o_result;

    // server state as predicted
    logic        srv_value;
    logic [7:0]  seen_tid;
    logic [15:0] seen_src;
    logic [25:0] queued_trans_ms;
    logic [25:0] countdown_ms;
    logic        countdown_run;
    logic        led_lvl;

    mos_pkg::t_out_item status_q [$];

    int  n_errors    = 0;
    int  n_results   = 0;
    int  n_sent      = 0;
    int  n_ticks     = 0;
    int  n_taken     = 0;
    int  n_ignored   = 0;
    int  n_expiry    = 0;
    int  n_stalled   = 0;
    int  quiet_left  = 0;
    int  hold_left   = 0;
    int  wait_left   = 0;
    bit  hold_req    = 1'b0;
    bit  hold_taken  = 1'b0;
    bit  send_busy   = 1'b1;
    bit  rcv_busy    = 1'b1;

    mesh_onoff_server_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic logic [7:0] encode_remaining(logic [25:0] ms);
        int unsigned t;
        t = 32'(ms);
        for (int i = 0; i < 4; i++) begin
            if (t < 63 * STEP_MS[i])
                return 8'((t + STEP_MS[i] - 1) / STEP_MS[i]) | 8'(i << 6);
        end
        return mos_pkg::CODE_OVERFLOW;
    endfunction

    function automatic void fire_expiry();
        n_expiry++;
        if (queued_trans_ms != 26'd0) begin
            led_lvl         = 1'b1;
            countdown_ms    = queued_trans_ms;
            queued_trans_ms = 26'd0;
            countdown_run   = 1'b1;
        end else begin
            led_lvl       = srv_value;
            countdown_run = 1'b0;
            countdown_ms  = 26'd0;
        end
    endfunction

    function automatic mos_pkg::t_out_item status_now();
        mos_pkg::t_out_item s;
        logic [25:0]        rem;
        s   = '0;
        rem = (countdown_run ? countdown_ms : 26'd0) + queued_trans_ms;
        s.status_valid = 1'b1;
        if (rem != 26'd0) begin
            s.present_value  = ~srv_value;
            s.has_target     = 1'b1;
            s.target_value   = srv_value;
            s.remaining_code = encode_remaining(rem);
        end else begin
            s.present_value = srv_value;
        end
        return s;
    endfunction

    function automatic mos_pkg::t_out_item predict_result(mos_pkg::t_in_item it);
        mos_pkg::t_out_item r;
        logic [25:0]        trans_ms;
        logic [25:0]        delay_ms;
        logic               fire_now;
        r        = '0;
        trans_ms = '0;
        delay_ms = '0;
        fire_now = 1'b0;
        case (it.opcode)
            mos_pkg::OP_TICK: begin
                if (countdown_run) begin
                    countdown_ms = countdown_ms - 26'd1;
                    if (countdown_ms == 26'd0)
                        fire_expiry();
                end
            end
            mos_pkg::OP_GET: begin
                r = status_now();
            end
            default: begin
                if (it.has_timing
                        && it.transition_code[5:0] == mos_pkg::STEPS_PROHIBITED) begin
                    n_ignored++;
                end else begin
                    if (it.has_timing) begin
                        trans_ms = 26'(it.transition_code[5:0] * STEP_MS[it.transition_code[7:6]]);
                        delay_ms = 26'(it.delay_code) * 26'(mos_pkg::DELAY_UNIT_MS);
                    end
                    if (!(it.transaction_id == seen_tid && it.source_address == seen_src)
                            && it.new_value != srv_value) begin
                        seen_tid        = it.transaction_id;
                        seen_src        = it.source_address;
                        srv_value       = it.new_value;
                        queued_trans_ms = trans_ms;
                        countdown_ms    = delay_ms;
                        countdown_run   = 1'b1;
                        fire_now        = (delay_ms == 26'd0);
                        n_taken++;
                    end
                    if (it.opcode == mos_pkg::OP_SET_ACK)
                        r = status_now();
                    if (fire_now)
                        fire_expiry();
                end
            end
        endcase
        r.led_on = led_lvl;
        return r;
    endfunction

    function automatic mos_pkg::t_in_item mk(logic [1:0] op, int val, logic [7:0] tid,
                                             logic [15:0] src, int timing, logic [7:0] tcode,
                                             logic [7:0] dcode);
        mos_pkg::t_in_item it;
        it.opcode          = op;
        it.new_value       = 1'(val);
        it.transaction_id  = tid;
        it.source_address  = src;
        it.has_timing      = 1'(timing);
        it.transition_code = tcode;
        it.delay_code      = dcode;
        return it;
    endfunction

    function automatic mos_pkg::t_out_item st(int sv, int pv, int ht, int tv,
                                              logic [7:0] rc, int led);
        mos_pkg::t_out_item r;
        r.status_valid   = 1'(sv);
        r.present_value  = 1'(pv);
        r.has_target     = 1'(ht);
        r.target_value   = 1'(tv);
        r.remaining_code = rc;
        r.led_on         = 1'(led);
        return r;
    endfunction

    task automatic send_item(input mos_pkg::t_in_item it, input bit typed,
                             input mos_pkg::t_out_item fixed);
        int                 gap;
        mos_pkg::t_out_item want;
        gap = (quiet_left > 0 || !send_busy) ? 0 : $urandom_range(0, 16);
        if (quiet_left > 0)
            quiet_left--;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) begin
            n_stalled++;
            @(posedge i_clk);
        end
        want = predict_result(it);
        status_q.push_back(typed ? fixed : want);
        if (it.opcode == mos_pkg::OP_TICK)
            n_ticks++;
        n_sent++;
        if (n_sent % 40 == 0)
            send_busy = 1'($urandom_range(0, 1));
    endtask

    task automatic report_field(input string field, input logic [7:0] want_v,
                                input logic [7:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want_v, got_v);
            n_errors++;
        end
    endtask

    // result side: scoreboard check and stall pattern
    always @(posedge i_clk) begin : result_side
        mos_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (status_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, got %p", $time, o_result);
                n_errors++;
            end else begin
                want = status_q.pop_front();
                report_field("status_valid", 8'(want.status_valid), 8'(o_result.status_valid));
                report_field("present_value", 8'(want.present_value),
                             8'(o_result.present_value));
                report_field("has_target", 8'(want.has_target), 8'(o_result.has_target));
                report_field("target_value", 8'(want.target_value), 8'(o_result.target_value));
                report_field("remaining_code", want.remaining_code, o_result.remaining_code);
                report_field("led_on", 8'(want.led_on), 8'(o_result.led_on));
            end
            if (n_results % 50 == 0)
                rcv_busy = 1'($urandom_range(0, 1));
            wait_left = rcv_busy ? $urandom_range(0, 16) : 0;
        end
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (wait_left > 0) begin
            wait_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial begin : limit
        #(RUN_LIMIT_NS);
        $display("mesh_onoff_server_unit_test: FAIL");
        $finish;
    end

    initial begin : stimulus
        t_table_row        plan [$];
        mos_pkg::t_in_item it;
        mos_pkg::t_in_item tick;
        int                pick;
        int                burst;
        bit                hold_done;
        bit                pause_done;

        hold_done  = 1'b0;
        pause_done = 1'b0;

        srv_value       = 1'b0;
        seen_tid        = '0;
        seen_src        = '0;
        queued_trans_ms = '0;
        countdown_ms    = '0;
        countdown_run   = 1'b0;
        led_lvl         = 1'b0;

        // reset state, duplicate at reset, unchanged value, prohibited steps
        plan.push_back(t_table_row'{mk(mos_pkg::OP_GET, 0, 8'h00, 16'h0000, 0, 8'h00, 8'h00),
                                    1'b1, st(1, 0, 0, 0, 8'h00, 0)});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_TICK, 0, 8'h00, 16'h0000, 0, 8'h00, 8'h00),
                                    1'b1, st(0, 0, 0, 0, 8'h00, 0)});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_SET_ACK, 1, 8'h00, 16'h0000, 0, 8'h00,
                                       8'h00),
                                    1'b1, st(1, 0, 0, 0, 8'h00, 0)});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_SET_ACK, 0, 8'h01, 16'h0001, 0, 8'h00,
                                       8'h00),
                                    1'b1, st(1, 0, 0, 0, 8'h00, 0)});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_SET_ACK, 1, 8'hff, 16'hffff, 1, 8'h3f,
                                       8'h00),
                                    1'b1, st(0, 0, 0, 0, 8'h00, 0)});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_SET_UNACK, 1, 8'hff, 16'hffff, 1, 8'hff,
                                       8'hff),
                                    1'b1, st(0, 0, 0, 0, 8'h00, 0)});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_SET_ACK, 1, 8'hff, 16'hffff, 0, 8'hff,
                                       8'hff),
                                    1'b1, st(1, 1, 0, 0, 8'h00, 1)});
        // transitions at every resolution, extremes of delay
        plan.push_back(t_table_row'{mk(mos_pkg::OP_SET_UNACK, 0, 8'h01, 16'h1234, 1, 8'h01,
                                       8'h00),
                                    1'b0, '0});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_GET, 0, 8'h00, 16'h0000, 0, 8'h00, 8'h00),
                                    1'b0, '0});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_TICK, 0, 8'h00, 16'h0000, 0, 8'h00, 8'h00),
                                    1'b0, '0});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_SET_ACK, 1, 8'h02, 16'h1234, 1, 8'h41,
                                       8'hff),
                                    1'b0, '0});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_SET_ACK, 0, 8'h02, 16'h1234, 1, 8'h00,
                                       8'h00),
                                    1'b0, '0});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_SET_ACK, 0, 8'h03, 16'h8000, 1, 8'h81,
                                       8'h00),
                                    1'b0, '0});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_GET, 0, 8'h00, 16'h0000, 0, 8'h00, 8'h00),
                                    1'b0, '0});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_SET_ACK, 1, 8'h04, 16'h0001, 1, 8'hc1,
                                       8'h80),
                                    1'b0, '0});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_SET_ACK, 0, 8'h05, 16'h0001, 1, 8'hfe,
                                       8'h7f),
                                    1'b0, '0});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_SET_ACK, 1, 8'h06, 16'h0002, 1, 8'h3e,
                                       8'h00),
                                    1'b0, '0});
        // timing bytes present but flag clear
        plan.push_back(t_table_row'{mk(mos_pkg::OP_SET_ACK, 0, 8'h07, 16'h0003, 0, 8'haa,
                                       8'h55),
                                    1'b1, st(1, 0, 0, 0, 8'h00, 0)});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_SET_UNACK, 0, 8'h07, 16'h0003, 0, 8'h00,
                                       8'h00),
                                    1'b1, st(0, 0, 0, 0, 8'h00, 0)});
        // short delay run to expiry
        plan.push_back(t_table_row'{mk(mos_pkg::OP_SET_UNACK, 1, 8'h08, 16'h0004, 1, 8'h00,
                                       8'h01),
                                    1'b0, '0});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_GET, 0, 8'h00, 16'h0000, 0, 8'h00, 8'h00),
                                    1'b0, '0});
        for (int k = 0; k < 5; k++)
            plan.push_back(t_table_row'{mk(mos_pkg::OP_TICK, 0, 8'h00, 16'h0000, 0, 8'h00,
                                           8'h00),
                                        1'b0, '0});
        plan.push_back(t_table_row'{mk(mos_pkg::OP_GET, 0, 8'h00, 16'h0000, 0, 8'h00, 8'h00),
                                    1'b0, '0});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k])
            send_item(plan[k].item, plan[k].typed, plan[k].result);

        while (n_sent < N_ITEMS) begin
            if (!hold_done && n_sent >= 150) begin
                hold_done  = 1'b1;
                hold_req   = 1'b1;
                quiet_left = 24;
            end
            if (!pause_done && n_sent >= 320) begin
                pause_done = 1'b1;
                i_valid <= 1'b0;
                while (status_q.size() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            it.opcode          = 2'($urandom_range(0, 3));
            it.new_value       = 1'($urandom);
            it.transaction_id  = 8'($urandom);
            it.source_address  = 16'($urandom);
            it.has_timing      = 1'($urandom);
            it.transition_code = 8'($urandom);
            it.delay_code      = 8'($urandom);
            tick        = it;
            tick.opcode = mos_pkg::OP_TICK;
            if (pick < 45) begin
                // a set that takes effect in most cases, then time passing with a few polls
                it.opcode = $urandom_range(0, 1) ? mos_pkg::OP_SET_ACK : mos_pkg::OP_SET_UNACK;
                if ($urandom_range(0, 7) != 0)
                    it.new_value = ~srv_value;
                it.transition_code = {2'b00, 6'($urandom_range(0, 1))};
                it.delay_code      = 8'($urandom_range(0, 3));
                send_item(it, 1'b0, '0);
                burst = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 180)
                                                    : $urandom_range(1, 12);
                for (int k = 0; k < burst && n_sent < N_ITEMS; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        it.opcode = mos_pkg::OP_GET;
                        send_item(it, 1'b0, '0);
                    end
                    send_item(tick, 1'b0, '0);
                end
            end else begin
                if (pick < 60) begin
                    it.opcode = mos_pkg::OP_GET;
                end else if (pick < 70) begin
                    it.opcode         = $urandom_range(0, 1) ? mos_pkg::OP_SET_ACK
                                                             : mos_pkg::OP_SET_UNACK;
                    it.transaction_id = seen_tid;
                    it.source_address = seen_src;
                end else if (pick < 78) begin
                    it.opcode                = $urandom_range(0, 1) ? mos_pkg::OP_SET_ACK
                                                                    : mos_pkg::OP_SET_UNACK;
                    it.has_timing            = 1'b1;
                    it.transition_code[5:0]  = mos_pkg::STEPS_PROHIBITED;
                end
                send_item(it, 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d transactions (%0d ticks): %0d sets took effect, %0d ignored.",
                 n_sent, n_ticks, n_taken, n_ignored);
        $display("Timer expiries: %0d; cycles with the input held off: %0d.",
                 n_expiry, n_stalled);
        if (n_errors == 0)
            $display("mesh_onoff_server_unit_test: PASS");
        else
            $display("mesh_onoff_server_unit_test: FAIL");
        $finish;
    end

endmodule
